// File: rtl/slin_pkg.sv
// Shared constants, calibration table and types for the sensor linearizer.
package slin_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int OUT_BITS     = 12;
   localparam int TABLE_POINTS = 17;
   localparam int SEG_COUNT    = TABLE_POINTS - 1;
   localparam int SEG_BITS     = $clog2(SEG_COUNT);
   localparam int DC_BITS      = 9;   // widest cal step (338)
   localparam int Q_BITS       = 16;  // offset * cal step stays below 2^16
   localparam int F_BITS       = 9;   // integer part of q / d never exceeds the cal step
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_BITS   = 26;
   localparam int QUEUE_DEPTH  = 4;

   // raw points, strictly descending
   localparam logic [SAMPLE_BITS-1:0] RAW_PT [TABLE_POINTS] = '{
      10'd1004, 10'd330, 10'd250, 10'd187, 10'd147, 10'd142, 10'd97, 10'd78, 10'd63,
      10'd50, 10'd47, 10'd43, 10'd40, 10'd36, 10'd32, 10'd30, 10'd23
   };

   // calibrated points, ascending
   localparam logic signed [OUT_BITS-1:0] CAL_PT [TABLE_POINTS] = '{
      -12'sd2, 12'sd47, 12'sd69, 12'sd86, 12'sd128, 12'sd154, 12'sd250, 12'sd336,
      12'sd474, 12'sd596, 12'sd692, 12'sd770, 12'sd930, 12'sd1268, 12'sd1392,
      12'sd1534, 12'sd1869
   };

   // segment width raw[i] - raw[i+1]
   localparam logic [SAMPLE_BITS-1:0] SEG_D [SEG_COUNT] = '{
      10'd674, 10'd80, 10'd63, 10'd40, 10'd5, 10'd45, 10'd19, 10'd15,
      10'd13, 10'd3, 10'd4, 10'd3, 10'd4, 10'd4, 10'd2, 10'd7
   };

   // segment rise cal[i+1] - cal[i]
   localparam logic [DC_BITS-1:0] SEG_DC [SEG_COUNT] = '{
      9'd49, 9'd22, 9'd17, 9'd42, 9'd26, 9'd96, 9'd86, 9'd138,
      9'd122, 9'd96, 9'd78, 9'd160, 9'd338, 9'd124, 9'd142, 9'd335
   };

   localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;

   // ceil(2^26 / d): exact floor division for every q below 2^16
   localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEG_COUNT] = '{
      RECIP_BITS'((RECIP_ONE + 674 - 1) / 674),
      RECIP_BITS'((RECIP_ONE + 80 - 1) / 80),
      RECIP_BITS'((RECIP_ONE + 63 - 1) / 63),
      RECIP_BITS'((RECIP_ONE + 40 - 1) / 40),
      RECIP_BITS'((RECIP_ONE + 5 - 1) / 5),
      RECIP_BITS'((RECIP_ONE + 45 - 1) / 45),
      RECIP_BITS'((RECIP_ONE + 19 - 1) / 19),
      RECIP_BITS'((RECIP_ONE + 15 - 1) / 15),
      RECIP_BITS'((RECIP_ONE + 13 - 1) / 13),
      RECIP_BITS'((RECIP_ONE + 3 - 1) / 3),
      RECIP_BITS'((RECIP_ONE + 4 - 1) / 4),
      RECIP_BITS'((RECIP_ONE + 3 - 1) / 3),
      RECIP_BITS'((RECIP_ONE + 4 - 1) / 4),
      RECIP_BITS'((RECIP_ONE + 4 - 1) / 4),
      RECIP_BITS'((RECIP_ONE + 2 - 1) / 2),
      RECIP_BITS'((RECIP_ONE + 7 - 1) / 7)
   };

   // classified word handed from front to back
   typedef struct packed {
      logic [SEG_BITS-1:0]    seg;
      logic [SAMPLE_BITS-1:0] off;
   } seg_word_type;

endpackage

// File: rtl/slin_front.sv
// Front end: accepts raw samples, clamps them and picks the table segment.
module slin_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [slin_pkg::SAMPLE_BITS-1:0] req_raw_reading,
   output logic                           push_valid,
   input  logic                           push_ready,
   output slin_pkg::seg_word_type         push_word
);
   import slin_pkg::*;

   logic                   valid_ff, valid_in;
   seg_word_type           word_ff, word_in;
   logic [SAMPLE_BITS-1:0] xc;
   logic [SEG_BITS-1:0]    seg;
   logic                   take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_word  = word_ff;

   // clamp: low end lands on the last segment at full offset, high end on
   // segment zero at offset zero, so no separate clamp path is needed
   always_comb begin
      xc = req_raw_reading;
      if (req_raw_reading <= RAW_PT[TABLE_POINTS-1]) begin
         xc = RAW_PT[TABLE_POINTS-1];
      end else if (req_raw_reading >= RAW_PT[0]) begin
         xc = RAW_PT[0];
      end
   end

   // descending table: the last of points 0 to SEG_COUNT-1 still at or above xc is the segment
   always_comb begin
      seg = '0;
      for (int k = 1; k < SEG_COUNT; k++) begin
         if (xc <= RAW_PT[k]) begin
            seg = SEG_BITS'(k);
         end
      end
   end

   always_comb begin
      word_in.seg = seg;
      word_in.off = RAW_PT[{1'b0, seg}] - xc;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         word_ff <= word_in;
      end
   end

endmodule

// File: rtl/slin_queue.sv
// Short FIFO that decouples the classifier from the arithmetic pipeline.
module slin_queue #(
   parameter int QUEUE_DEPTH = slin_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  slin_pkg::seg_word_type push_word,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output slin_pkg::seg_word_type pop_word
);
   import slin_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   seg_word_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: rtl/slin_back.sv
// Back end: interpolation pipeline (scale, reciprocal divide, remainder, round).
module slin_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  slin_pkg::seg_word_type              pop_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [slin_pkg::OUT_BITS-1:0] rsp_calibrated_value
);
   import slin_pkg::*;

   logic advance;

   // stage 1: q = off * rise
   logic                    v1_ff;
   logic [SEG_BITS-1:0]     seg1_ff;
   logic [Q_BITS-1:0]       q1_ff;
   logic [SAMPLE_BITS+DC_BITS-1:0] q_full;

   // stage 2: f = floor(q / d) by reciprocal
   logic                    v2_ff;
   logic [SEG_BITS-1:0]     seg2_ff;
   logic [Q_BITS-1:0]       q2_ff;
   logic [F_BITS-1:0]       f2_ff;
   logic [Q_BITS+RECIP_BITS-1:0] f_full;

   // stage 3: remainder and integer base
   logic                    v3_ff;
   logic [SAMPLE_BITS-1:0]  d3_ff;
   logic [SAMPLE_BITS-1:0]  rem3_ff;
   logic signed [OUT_BITS-1:0] base3_ff;
   logic [F_BITS+SAMPLE_BITS-1:0] fd_full;
   logic [Q_BITS-1:0]       rem_full;
   logic signed [OUT_BITS-1:0] base_in;

   // output register
   logic                    rsp_valid_ff;
   logic signed [OUT_BITS-1:0] rsp_value_ff;
   logic [SAMPLE_BITS:0]    rem_x2;
   logic [SAMPLE_BITS:0]    d_ext;
   logic                    round_up;
   logic signed [OUT_BITS-1:0] result_in;

   // whole pipe moves together; it only holds while the output word waits
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   assign q_full  = {{DC_BITS{1'b0}}, pop_word.off} * {{SAMPLE_BITS{1'b0}}, SEG_DC[pop_word.seg]};
   assign f_full  = {{RECIP_BITS{1'b0}}, q1_ff} * {{Q_BITS{1'b0}}, SEG_RECIP[seg1_ff]};
   assign fd_full = {{SAMPLE_BITS{1'b0}}, f2_ff} * {{F_BITS{1'b0}}, SEG_D[seg2_ff]};
   assign rem_full = q2_ff - fd_full[Q_BITS-1:0];
   assign base_in  = CAL_PT[{1'b0, seg2_ff}] + $signed({{(OUT_BITS-F_BITS){1'b0}}, f2_ff});

   // half rounds away from zero: up on a tie only when the base is not negative
   assign rem_x2   = {rem3_ff, 1'b0};
   assign d_ext    = {1'b0, d3_ff};
   assign round_up = (rem_x2 > d_ext) || ((rem_x2 == d_ext) && !base3_ff[OUT_BITS-1]);
   assign result_in = base3_ff + $signed({{(OUT_BITS-1){1'b0}}, round_up});

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_calibrated_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
      if (advance) begin
         seg1_ff      <= pop_word.seg;
         q1_ff        <= q_full[Q_BITS-1:0];
         seg2_ff      <= seg1_ff;
         q2_ff        <= q1_ff;
         f2_ff        <= f_full[RECIP_SHIFT +: F_BITS];
         d3_ff        <= SEG_D[seg2_ff];
         rem3_ff      <= rem_full[SAMPLE_BITS-1:0];
         base3_ff     <= base_in;
         rsp_value_ff <= result_in;
      end
   end

endmodule

// File: rtl/sensor_piecewise_linearizer_core.sv
// Top level of the light-sensor piecewise-linear linearizer.
//
// Usage:
//  - req_ channel carries one raw converter word (req_raw_reading, unsigned);
//    rsp_ channel returns one calibrated word (rsp_calibrated_value, signed).
//  - Both channels are valid/ready; a word moves when valid and ready are high.
//  - Readings at or below 23 give 1869, at or above 1004 give -2; between them
//    the value is interpolated over a 17-point table, rounded half away from 0.
//  - Throughput: one word per cycle, sustained, with no stalls downstream.
//  - Path from req acceptance to rsp_valid with an empty pipe:
//    classifier register, queue, three arithmetic stages, output register.
//  - The front classifies into a short queue; the back pipeline moves as a
//    whole and holds only while rsp_valid is high and rsp_ready is low.
//    The front keeps taking words until the queue and its own register fill, then drops req_ready.
//  - Reset (synchronous, active high) empties the queue and all stages;
//    no table or state needs filling, so req_ready is up right after reset.
module sensor_piecewise_linearizer_core #(
   parameter int QUEUE_DEPTH = slin_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [slin_pkg::SAMPLE_BITS-1:0]     req_raw_reading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [slin_pkg::OUT_BITS-1:0] rsp_calibrated_value
);
   import slin_pkg::*;

   // classifier -> queue
   logic         push_valid;
   logic         push_ready;
   seg_word_type push_word;

   // queue -> arithmetic pipeline
   logic         pop_valid;
   logic         pop_ready;
   seg_word_type pop_word;

   slin_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_reading (req_raw_reading),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_word       (push_word)
   );

   slin_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   slin_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_word             (pop_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_calibrated_value (rsp_calibrated_value)
   );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sensor piecewise-linear linearizer core.
`timescale 1ns / 1ps

module tb_top;

   import slin_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;
   localparam int DRAIN_WAIT  = 20;   // longer than the pipe latency

   // Independent copy of the calibration curve: raw descending, cal ascending.
   localparam int NPTS = 17;
   localparam int RAW_TBL [NPTS] = '{
      1004, 330, 250, 187, 147, 142, 97, 78, 63, 50, 47, 43, 40, 36, 32, 30, 23
   };
   localparam int CAL_TBL [NPTS] = '{
      -2, 47, 69, 86, 128, 154, 250, 336, 474, 596, 692, 770, 930, 1268, 1392,
      1534, 1869
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SAMPLE_BITS-1:0]     req_raw_reading = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_calibrated_value;

   logic [SAMPLE_BITS-1:0]     reading_q [$];     // words waiting to be offered
   logic signed [OUT_BITS-1:0] cal_expect_q [$];  // predicted values, oldest first

   logic word_sent     = 1'b0;  // req word accepted at the last rising edge
   logic idle_on       = 1'b1;  // random bubbles on both channels
   logic hold_request  = 1'b0;  // ask the receiver for one long hold-off
   logic hold_taken    = 1'b0;
   int   req_gap_left  = 0;
   int   rsp_gap_left  = 0;
   int   rsp_hold_left = 0;
   int   err_cnt       = 0;
   int   cycle_cnt     = 0;

   sensor_piecewise_linearizer_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_raw_reading      (req_raw_reading),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_calibrated_value (rsp_calibrated_value)
   );

   always #6 clock = ~clock;

   // Interpolate one reading over the table, rounding halves away from zero.
   function automatic logic signed [OUT_BITS-1:0] calibrate_reading(
      logic [SAMPLE_BITS-1:0] x
   );
      longint xi, d, num, q;
      int     seg, i;
      bit     found;
      xi    = x;
      seg   = 0;
      found = 1'b0;
      if (xi <= RAW_TBL[NPTS-1]) begin
         q = CAL_TBL[NPTS-1];
      end else if (xi >= RAW_TBL[0]) begin
         q = CAL_TBL[0];
      end else begin
         for (i = 0; i < NPTS - 1; i++) begin
            if (!found && RAW_TBL[i] >= xi && xi > RAW_TBL[i+1]) begin
               seg   = i;
               found = 1'b1;
            end
         end
         d   = RAW_TBL[seg] - RAW_TBL[seg+1];
         num = longint'(CAL_TBL[seg]) * d
             + (RAW_TBL[seg] - xi) * (CAL_TBL[seg+1] - CAL_TBL[seg]);
         // integer division truncates toward zero, so fold the sign by hand
         if (num >= 0)
            q = (2 * num + d) / (2 * d);
         else
            q = -((-2 * num + d) / (2 * d));
      end
      return OUT_BITS'(q);
   endfunction

   // Random readings weighted toward the dense low segments of the curve.
   task automatic queue_random_readings(int n);
      int k, pick;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            reading_q.push_back(SAMPLE_BITS'($urandom_range(18, 340)));
         else if (pick < 8)
            reading_q.push_back(SAMPLE_BITS'($urandom_range(320, 1010)));
         else
            reading_q.push_back(SAMPLE_BITS'($urandom_range(0, 1023)));
      end
   endtask

   // Sender: holds a word until taken, then either bubbles or offers the next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !word_sent)) begin
         if (req_gap_left > 0) begin
            req_gap_left <= req_gap_left - 1;
            req_valid    <= 1'b0;
         end else if (reading_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            req_gap_left <= $urandom_range(0, 7);
            req_valid    <= 1'b0;
         end else begin
            req_valid       <= 1'b1;
            req_raw_reading <= reading_q.pop_front();
         end
      end
   end

   // Receiver: random stall bursts plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready     <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken    <= 1'b1;
         rsp_hold_left <= LONG_HOLD - 1;
         rsp_ready     <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left <= rsp_gap_left - 1;
         rsp_ready    <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_gap_left <= $urandom_range(0, 7);
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Input monitor: predict each accepted word.
   always @(posedge clock) begin
      word_sent <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         cal_expect_q.push_back(calibrate_reading(req_raw_reading));
   end

   // Output monitor: compare against the oldest prediction.
   always @(posedge clock) begin
      logic signed [OUT_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cal_expect_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
               $display("ERROR: unexpected word, value %0d", rsp_calibrated_value);
         end else begin
            want = cal_expect_q.pop_front();
            if (rsp_calibrated_value !== want) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("ERROR: calibrated_value expected %0d got %0d",
                           want, rsp_calibrated_value);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Wait until the sender is empty and every predicted word has come back.
   task automatic wait_drained();
      while (reading_q.size() != 0 || req_valid || cal_expect_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: clamps on both sides, every breakpoint, a rounding half
      reading_q.push_back(10'd0);
      reading_q.push_back(10'd1023);
      reading_q.push_back(10'd22);
      reading_q.push_back(10'd24);
      reading_q.push_back(10'd1003);
      reading_q.push_back(10'd1005);
      for (k = 0; k < NPTS; k++)
         reading_q.push_back(SAMPLE_BITS'(RAW_TBL[k]));
      reading_q.push_back(10'd39);   // exact half in a width-4 segment
      reading_q.push_back(10'd512);
      wait_drained();

      // random with bubbles; one long receiver hold-off fills the pipe
      queue_random_readings(250);
      @(posedge clock);
      hold_request = 1'b1;
      wait_drained();

      queue_random_readings(250);
      wait_drained();

      // last stretch at full rate
      idle_on = 1'b0;
      queue_random_readings(100);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (cal_expect_q.size() != 0)
         err_cnt++;
      if (err_cnt == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
